@@ sv/mbx_pkg.sv @@
// Shared types, constants and request codes for the two-endpoint mailbox FIFO.
// Used by mbx_ctrl, mbx_queue and two_endpoint_mailbox_fifo; no dependencies.
package mbx_pkg;

  localparam int DEPTH       = 16;
  localparam int ID_BITS     = 16;
  localparam int HANDLE_BITS = 32;
  localparam int LEN_W       = 16;
  localparam int REQ_W       = 3;
  localparam int DREQ_W      = 14;
  localparam int LINK_W      = 2;
  localparam int FILL_W      = 5;

  localparam int CNT_W = $clog2(DEPTH + 1);
  localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;

  localparam logic [REQ_W-1:0] REQ_OPEN        = 3'd0;
  localparam logic [REQ_W-1:0] REQ_CONNECT     = 3'd1;
  localparam logic [REQ_W-1:0] REQ_WRITE       = 3'd2;
  localparam logic [REQ_W-1:0] REQ_READ        = 3'd3;
  localparam logic [REQ_W-1:0] REQ_DISCONNECT  = 3'd4;
  localparam logic [REQ_W-1:0] REQ_SESSION_END = 3'd5;
  localparam logic [REQ_W-1:0] REQ_STATUS      = 3'd6;

  localparam logic [LINK_W-1:0] LINK_NONE        = 2'd0;
  localparam logic [LINK_W-1:0] LINK_UNCONNECTED = 2'd1;
  localparam logic [LINK_W-1:0] LINK_CONNECTED   = 2'd2;

  typedef struct packed {
    logic [REQ_W-1:0]       req_type;
    logic [ID_BITS-1:0]     endpoint_id;
    logic [HANDLE_BITS-1:0] packet_handle;
    logic [LEN_W-1:0]       packet_length;
    logic                   end_kill;
    logic [DREQ_W-1:0]      depth_request;
  } req_t;

  typedef struct packed {
    logic                   accepted;
    logic [HANDLE_BITS-1:0] read_handle;
    logic [LEN_W-1:0]       read_length;
    logic [LINK_W-1:0]      link_status;
    logic [FILL_W-1:0]      own_fill;
    logic [FILL_W-1:0]      peer_fill;
    logic                   tube_gone;
    logic                   drop_flag;
    logic [HANDLE_BITS-1:0] drop_handle;
  } res_t;

  typedef struct packed {
    logic [HANDLE_BITS-1:0] handle;
    logic [LEN_W-1:0]       length;
  } entry_t;

  typedef struct packed {
    logic       push;
    logic       pop;
    logic       side;
    logic [1:0] clr;
  } qop_t;

  function automatic logic [CNT_W-1:0] clamp_limit(input logic [DREQ_W-1:0] req);
    logic [CNT_W-1:0] lim;
    if (req == '0) begin
      lim = CNT_W'(1);
    end else if (req > DREQ_W'(DEPTH)) begin
      lim = CNT_W'(DEPTH);
    end else begin
      lim = req[CNT_W-1:0];
    end
    return lim;
  endfunction

endpackage

@@ sv/two_endpoint_mailbox_fifo.sv @@
// Top level of the two-endpoint mailbox FIFO: request register, slot control,
// receive queues and result register. Depends on mbx_pkg, mbx_ctrl, mbx_queue.
//
//   Channel  Direction  Beat content
//   in_*     slave      one request: kind in tuser, operands in tdata
//   out_*    master     one result per request
//
// Sustains one request per cycle while results are not stalled; a request beat is
// captured in the request register, passes the single decode and queue update
// pass and is held in the result register, which drives out_* as its result.
// Synchronous reset clears slot state, queue heads and counts.
// A stalled result holds in the result register while the next request waits
// in the request register.
module two_endpoint_mailbox_fifo (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [79:0] in_tdata,  // endpoint_id, packet_handle, packet_length, end_kill,
                                 // depth_request, zero pad
  input  logic [2:0]  in_tuser,  // req_type
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [95:0] out_tdata  // accepted, read_handle, read_length, link_status,
                                 // own_fill, peer_fill, tube_gone, drop_flag,
                                 // drop_handle, zero pad
);
  import mbx_pkg::*;

  logic                   in_vld_r;
  req_t                   in_data_r;
  logic                   out_vld_r;
  res_t                   out_data_r;
  logic                   fire;
  req_t                   in_req;
  res_t                   res;
  qop_t                   qop;
  entry_t                 wr_entry;
  entry_t                 rd_entry;
  logic [1:0][CNT_W-1:0]  qcount;

  assign fire      = in_vld_r && (!out_vld_r || out_tready);
  assign in_tready = !in_vld_r || fire;

  always_comb begin
    in_req.req_type      = in_tuser;
    in_req.endpoint_id   = in_tdata[15:0];
    in_req.packet_handle = in_tdata[47:16];
    in_req.packet_length = in_tdata[63:48];
    in_req.end_kill      = in_tdata[64];
    in_req.depth_request = in_tdata[78:65];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_vld_r <= 1'b0;
    end else if (in_tvalid && in_tready) begin
      in_vld_r <= 1'b1;
    end else if (fire) begin
      in_vld_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_tvalid && in_tready) begin
      in_data_r <= in_req;
    end
  end

  assign wr_entry.handle = in_data_r.packet_handle;
  assign wr_entry.length = in_data_r.packet_length;

  mbx_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .fire     (fire),
    .req      (in_data_r),
    .qcount   (qcount),
    .rd_entry (rd_entry),
    .qop      (qop),
    .res      (res)
  );

  mbx_queue u_queue (
    .clk      (clk),
    .rst_n    (rst_n),
    .fire     (fire),
    .qop      (qop),
    .wr_entry (wr_entry),
    .qcount   (qcount),
    .rd_entry (rd_entry)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_vld_r <= 1'b0;
    end else if (fire) begin
      out_vld_r <= 1'b1;
    end else if (out_tready) begin
      out_vld_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (fire) begin
      out_data_r <= res;
    end
  end

  assign out_tvalid = out_vld_r;
  assign out_tdata  = {1'b0,
                       out_data_r.drop_handle,
                       out_data_r.drop_flag,
                       out_data_r.tube_gone,
                       out_data_r.peer_fill,
                       out_data_r.own_fill,
                       out_data_r.link_status,
                       out_data_r.read_length,
                       out_data_r.read_handle,
                       out_data_r.accepted};

endmodule

@@ sv/mbx_queue.sv @@
// Receive FIFOs of the two physical slots: heads, fill counts and entry storage.
// Depends on mbx_pkg; driven by the queue operation from mbx_ctrl.
module mbx_queue (
  input  logic                             clk,
  input  logic                             rst_n,
  input  logic                             fire,
  input  mbx_pkg::qop_t                    qop,
  input  mbx_pkg::entry_t                  wr_entry,
  output logic [1:0][mbx_pkg::CNT_W-1:0]   qcount,
  output mbx_pkg::entry_t                  rd_entry
);
  import mbx_pkg::*;

  logic [PTR_W-1:0] head_r  [2];
  logic [CNT_W-1:0] count_r [2];
  entry_t           store_r [2][DEPTH];

  logic [CNT_W:0]   wr_sum;
  logic [PTR_W-1:0] wr_idx;
  logic [PTR_W-1:0] head_inc;

  always_comb begin
    wr_sum = {1'b0, count_r[qop.side]} + (CNT_W+1)'(head_r[qop.side]);
    if (wr_sum >= (CNT_W+1)'(DEPTH)) begin
      wr_sum = wr_sum - (CNT_W+1)'(DEPTH);
    end
    wr_idx = wr_sum[PTR_W-1:0];
    if (head_r[qop.side] == PTR_W'(DEPTH - 1)) begin
      head_inc = '0;
    end else begin
      head_inc = head_r[qop.side] + PTR_W'(1);
    end
  end

  assign qcount[0] = count_r[0];
  assign qcount[1] = count_r[1];
  assign rd_entry  = store_r[qop.side][head_r[qop.side]];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int q = 0; q < 2; q++) begin
        head_r[q]  <= '0;
        count_r[q] <= '0;
      end
    end else if (fire) begin
      for (int q = 0; q < 2; q++) begin
        if (qop.clr[q]) begin
          head_r[q]  <= '0;
          count_r[q] <= '0;
        end else if (qop.side == 1'(q)) begin
          if (qop.pop) begin
            head_r[q] <= head_inc;
          end
          count_r[q] <= count_r[q] + CNT_W'(qop.push) - CNT_W'(qop.pop);
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (fire && qop.push) begin
      store_r[qop.side][wr_idx] <= wr_entry;
    end
  end

endmodule

@@ sv/mbx_ctrl.sv @@
// Endpoint slot registers, request decode and result formation for the mailbox.
// Depends on mbx_pkg; steers mbx_queue through a qop_t and reads its counts.
module mbx_ctrl (
  input  logic                             clk,
  input  logic                             rst_n,
  input  logic                             fire,
  input  mbx_pkg::req_t                    req,
  input  logic [1:0][mbx_pkg::CNT_W-1:0]   qcount,
  input  mbx_pkg::entry_t                  rd_entry,
  output mbx_pkg::qop_t                    qop,
  output mbx_pkg::res_t                    res
);
  import mbx_pkg::*;

  logic [ID_BITS-1:0] id_r      [2];
  logic [1:0]         present_r;
  logic [1:0]         kill_r;
  logic [CNT_W-1:0]   limit_r   [2];
  logic               swap_r;

  logic [ID_BITS-1:0] id_nxt    [2];
  logic [1:0]         present_nxt;
  logic [1:0]         kill_nxt;
  logic [CNT_W-1:0]   limit_nxt [2];
  logic               swap_nxt;

  logic               p0, p1;
  logic               m0, m1, hit, own;
  logic [ID_BITS-1:0] tid;
  logic               l_p0, l_p1;
  logic               lv_rm1, lv_rm0, lv_close;
  logic               do_rm1, do_rm0, do_close, do_open, do_connect;
  logic               ses_a, ses_b;
  logic [CNT_W-1:0]   wcnt;
  logic               drop;

  always_comb begin
    p0  = swap_r;
    p1  = ~swap_r;
    m0  = present_r[p0] && (id_r[p0] == req.endpoint_id);
    m1  = present_r[p1] && (id_r[p1] == req.endpoint_id);
    hit = m0 || m1;
    own = (!m0) ^ swap_r;

    tid  = (req.req_type == REQ_SESSION_END) ? id_r[p0] : req.endpoint_id;
    l_p1 = present_r[p1] && (id_r[p1] == tid);
    l_p0 = present_r[p0] && (id_r[p0] == tid);
    lv_rm1   = l_p1;
    lv_rm0   = !l_p1 && l_p0 && present_r[p1];
    lv_close = !l_p1 && l_p0 && !present_r[p1];

    ses_a = present_r[p1] && kill_r[p1];
    ses_b = present_r[p0] && kill_r[p0];

    wcnt = qcount[~own];
    drop = (wcnt >= limit_r[~own]) && (wcnt != '0);
  end

  always_comb begin
    do_rm1     = 1'b0;
    do_rm0     = 1'b0;
    do_close   = 1'b0;
    do_open    = 1'b0;
    do_connect = 1'b0;
    qop        = '0;
    qop.side   = own;
    res        = '0;

    unique case (req.req_type)
      REQ_OPEN: begin
        do_close = 1'b1;
        do_open  = 1'b1;
      end
      REQ_CONNECT: begin
        do_connect = present_r[p0];
      end
      REQ_WRITE: begin
        qop.side = ~own;
        if (hit) begin
          res.accepted    = 1'b1;
          qop.push        = 1'b1;
          qop.pop         = drop;
          res.drop_flag   = drop;
          res.drop_handle = drop ? rd_entry.handle : '0;
        end
      end
      REQ_READ: begin
        if (hit && (qcount[own] != '0)) begin
          qop.pop         = 1'b1;
          res.accepted    = 1'b1;
          res.read_handle = rd_entry.handle;
          res.read_length = rd_entry.length;
        end
      end
      REQ_DISCONNECT: begin
        do_rm1   = lv_rm1;
        do_rm0   = lv_rm0;
        do_close = lv_close;
      end
      REQ_SESSION_END: begin
        if (ses_a) begin
          do_rm1   = 1'b1;
          do_close = ses_b;
        end else if (ses_b) begin
          do_rm1   = lv_rm1;
          do_rm0   = lv_rm0;
          do_close = lv_close;
        end
      end
      REQ_STATUS: begin
        if (hit) begin
          res.own_fill = FILL_W'(qcount[own]);
          if (present_r[p1]) begin
            res.link_status = LINK_CONNECTED;
            res.peer_fill   = FILL_W'(qcount[~own]);
          end else begin
            res.link_status = LINK_UNCONNECTED;
          end
        end
      end
      default: begin
      end
    endcase

    res.tube_gone = do_close && (req.req_type != REQ_OPEN);

    id_nxt      = id_r;
    present_nxt = present_r;
    kill_nxt    = kill_r;
    limit_nxt   = limit_r;
    swap_nxt    = swap_r;

    if (do_rm1) begin
      present_nxt[p1] = 1'b0;
      kill_nxt[p1]    = 1'b1;
      qop.clr[p1]     = 1'b1;
    end
    if (do_rm0) begin
      present_nxt[p0] = 1'b0;
      kill_nxt[p0]    = 1'b1;
      qop.clr[p0]     = 1'b1;
      swap_nxt        = ~swap_r;
    end
    if (do_close) begin
      for (int q = 0; q < 2; q++) begin
        id_nxt[q]    = '0;
        limit_nxt[q] = CNT_W'(DEPTH);
      end
      present_nxt = '0;
      kill_nxt    = '1;
      swap_nxt    = 1'b0;
      qop.clr     = '1;
    end
    if (do_open) begin
      id_nxt[0]      = req.endpoint_id;
      present_nxt[0] = 1'b1;
      kill_nxt[0]    = req.end_kill;
      limit_nxt[0]   = clamp_limit(req.depth_request);
    end
    if (do_connect) begin
      id_nxt[p1]      = req.endpoint_id;
      present_nxt[p1] = 1'b1;
      kill_nxt[p1]    = req.end_kill;
      limit_nxt[p1]   = clamp_limit(req.depth_request);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int q = 0; q < 2; q++) begin
        id_r[q]    <= '0;
        limit_r[q] <= CNT_W'(DEPTH);
      end
      present_r <= '0;
      kill_r    <= '1;
      swap_r    <= 1'b0;
    end else if (fire) begin
      id_r      <= id_nxt;
      present_r <= present_nxt;
      kill_r    <= kill_nxt;
      limit_r   <= limit_nxt;
      swap_r    <= swap_nxt;
    end
  end

endmodule

@@ sv/mbx_checker.sv @@
// Port-level checks on the mailbox result stream, bound to the top level.
// Depends only on the ports of two_endpoint_mailbox_fifo.
module mbx_checker (
  input logic        clk,
  input logic        rst_n,
  input logic        out_tvalid,
  input logic        out_tready,
  input logic [95:0] out_tdata
);

  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid && $stable(out_tdata))
    else $error("Stalled result beat changed.");

  a_link_code: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid |-> out_tdata[50:49] != 2'b11)
    else $error("Result carries an undefined link status.");

  a_drop_accepted: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && out_tdata[62] |-> out_tdata[0])
    else $error("Dropped entry reported on a write that was not accepted.");

  a_gone_quiet: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && out_tdata[61] |-> out_tdata[0] == 1'b0 && out_tdata[60:49] == 12'd0)
    else $error("Tube closure reported together with transfer or status fields.");

  a_fill_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid |-> out_tdata[55:51] <= 5'd16 && out_tdata[60:56] <= 5'd16)
    else $error("Reported fill exceeds the queue depth.");

endmodule

bind two_endpoint_mailbox_fifo mbx_checker u_mbx_checker (.*);

@@ tb/sv/two_endpoint_mailbox_fifo_test.sv @@
// Self-checking testbench for two_endpoint_mailbox_fifo: a directed table, then random requests.
// Typed rows check against the table, other beats against a behavioral predictor in this file.
// Depends on mbx_pkg and the two_endpoint_mailbox_fifo RTL.
module two_endpoint_mailbox_fifo_test;
  timeunit 1ns;
  timeprecision 1ps;

  import mbx_pkg::*;

  localparam logic [REQ_W-1:0] REQ_UNUSED = 3'd7;
  localparam int RANDOM_REQUESTS = 1700;
  localparam int STALL_LIMIT = 5000;

  typedef struct packed {
    req_t             rq;
    logic             typed;
    res_t             want;
  } dir_row_t;

  logic        clk;
  logic        rst_n;
  logic        in_tvalid;
  logic        in_tready;
  logic [79:0] in_tdata;
  logic [2:0]  in_tuser;
  logic        out_tvalid;
  logic        out_tready;
  logic [95:0] out_tdata;

  logic [ID_BITS-1:0]     ep_id    [2];
  logic                   ep_live  [2];
  logic                   ep_kill  [2];
  int                     ep_limit [2];
  logic [HANDLE_BITS-1:0] q_hdl    [2][DEPTH];
  logic [LEN_W-1:0]       q_len    [2][DEPTH];
  int                     q_head   [2];
  int                     q_count  [2];
  int                     swap_bit;

  res_t     pending_results[$];
  dir_row_t dir_rows[$];
  int       mismatches;
  int       quiet_cycles;
  bit       no_idle;

  two_endpoint_mailbox_fifo dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .in_tdata  (in_tdata),
    .in_tuser  (in_tuser),
    .out_tvalid(out_tvalid),
    .out_tready(out_tready),
    .out_tdata (out_tdata)
  );

  initial begin
    clk = 1'b0;
    forever #6 clk = ~clk;
  end

  function automatic void shut_tube();
    for (int p = 0; p < 2; p++) begin
      ep_id[p]    = '0;
      ep_live[p]  = 1'b0;
      ep_kill[p]  = 1'b1;
      ep_limit[p] = DEPTH;
      q_head[p]   = 0;
      q_count[p]  = 0;
    end
    swap_bit = 0;
  endfunction

  function automatic int find_side(input logic [ID_BITS-1:0] id);
    int p;
    for (int s = 0; s < 2; s++) begin
      p = s ^ swap_bit;
      if (ep_live[p] && ep_id[p] == id) return s;
    end
    return -1;
  endfunction

  // Removes an endpoint; the connector side is matched first. Returns 1 when the tube closes.
  function automatic bit detach(input logic [ID_BITS-1:0] id);
    int p0;
    int p1;
    p0 = swap_bit;
    p1 = p0 ^ 1;
    if (ep_live[p1] && ep_id[p1] == id) begin
      ep_live[p1] = 1'b0;
      ep_kill[p1] = 1'b1;
      q_head[p1]  = 0;
      q_count[p1] = 0;
      return 1'b0;
    end
    if (ep_live[p0] && ep_id[p0] == id) begin
      if (!ep_live[p1]) begin
        shut_tube();
        return 1'b1;
      end
      swap_bit = swap_bit ^ 1;
      ep_live[p0] = 1'b0;
      ep_kill[p0] = 1'b1;
      q_head[p0]  = 0;
      q_count[p0] = 0;
    end
    return 1'b0;
  endfunction

  function automatic res_t mailbox_outcome(input req_t rq);
    res_t r;
    int   s;
    int   p;
    int   lim;
    int   i;
    bit   gone;
    r = '0;
    if (rq.depth_request == '0) lim = 1;
    else if (rq.depth_request > DEPTH) lim = DEPTH;
    else lim = int'(rq.depth_request);
    case (rq.req_type)
      REQ_OPEN: begin
        shut_tube();
        ep_id[0]    = rq.endpoint_id;
        ep_live[0]  = 1'b1;
        ep_kill[0]  = rq.end_kill;
        ep_limit[0] = lim;
      end
      REQ_CONNECT: begin
        if (ep_live[swap_bit]) begin
          p = swap_bit ^ 1;
          ep_id[p]    = rq.endpoint_id;
          ep_live[p]  = 1'b1;
          ep_kill[p]  = rq.end_kill;
          ep_limit[p] = lim;
        end
      end
      REQ_WRITE: begin
        s = find_side(rq.endpoint_id);
        if (s >= 0) begin
          p = (s ^ 1 ^ swap_bit) & 1;
          r.accepted = 1'b1;
          if (q_count[p] >= ep_limit[p] && q_count[p] > 0) begin
            r.drop_flag   = 1'b1;
            r.drop_handle = q_hdl[p][q_head[p]];
            q_head[p]  = (q_head[p] + 1) % DEPTH;
            q_count[p] = q_count[p] - 1;
          end
          i = (q_head[p] + q_count[p]) % DEPTH;
          q_hdl[p][i] = rq.packet_handle;
          q_len[p][i] = rq.packet_length;
          q_count[p]  = q_count[p] + 1;
        end
      end
      REQ_READ: begin
        s = find_side(rq.endpoint_id);
        if (s >= 0) begin
          p = (s ^ swap_bit) & 1;
          if (q_count[p] > 0) begin
            r.accepted    = 1'b1;
            r.read_handle = q_hdl[p][q_head[p]];
            r.read_length = q_len[p][q_head[p]];
            q_head[p]  = (q_head[p] + 1) % DEPTH;
            q_count[p] = q_count[p] - 1;
          end
        end
      end
      REQ_DISCONNECT: begin
        r.tube_gone = detach(rq.endpoint_id);
      end
      REQ_SESSION_END: begin
        gone = 1'b0;
        p = swap_bit ^ 1;
        if (ep_live[p] && ep_kill[p]) gone = detach(ep_id[p]);
        p = swap_bit;
        if (!gone && ep_live[p] && ep_kill[p]) gone = detach(ep_id[p]);
        r.tube_gone = gone;
      end
      REQ_STATUS: begin
        s = find_side(rq.endpoint_id);
        if (s >= 0) begin
          p = (s ^ swap_bit) & 1;
          r.own_fill = FILL_W'(q_count[p]);
          if (ep_live[swap_bit ^ 1]) begin
            r.link_status = LINK_CONNECTED;
            r.peer_fill   = FILL_W'(q_count[p ^ 1]);
          end else begin
            r.link_status = LINK_UNCONNECTED;
          end
        end
      end
      default: begin
      end
    endcase
    return r;
  endfunction

  function automatic dir_row_t row(input logic [REQ_W-1:0] kind, input logic [ID_BITS-1:0] id,
                                   input logic [HANDLE_BITS-1:0] handle,
                                   input logic [LEN_W-1:0] len, input logic kill,
                                   input logic [DREQ_W-1:0] depth, input logic typed,
                                   input logic acc, input logic [LINK_W-1:0] link);
    dir_row_t d;
    d.rq.req_type      = kind;
    d.rq.endpoint_id   = id;
    d.rq.packet_handle = handle;
    d.rq.packet_length = len;
    d.rq.end_kill      = kill;
    d.rq.depth_request = depth;
    d.typed            = typed;
    d.want             = '0;
    d.want.accepted    = acc;
    d.want.link_status = link;
    return d;
  endfunction

  function automatic void add_row(input dir_row_t d);
    dir_rows.insert(dir_rows.size(), d);
  endfunction

  function automatic logic [ID_BITS-1:0] pick_id();
    int r;
    r = $urandom_range(0, 99);
    if (r < 40 && ep_live[swap_bit]) return ep_id[swap_bit];
    if (r < 80 && ep_live[swap_bit ^ 1]) return ep_id[swap_bit ^ 1];
    if (r < 90) return ep_id[$urandom_range(0, 1)];
    return ID_BITS'($urandom);
  endfunction

  // Mostly well-formed traffic from the live endpoints, with some unknown ids and noise.
  function automatic req_t random_request();
    req_t rq;
    int   w;
    rq.packet_handle = $urandom;
    rq.packet_length = LEN_W'($urandom);
    rq.end_kill      = 1'($urandom_range(0, 1));
    if ($urandom_range(0, 4) == 0) rq.depth_request = DREQ_W'($urandom);
    else rq.depth_request = DREQ_W'($urandom_range(0, DEPTH + 2));
    rq.endpoint_id = pick_id();
    w = $urandom_range(0, 99);
    if (!ep_live[swap_bit] && $urandom_range(0, 1) == 0) rq.req_type = REQ_OPEN;
    else if (!ep_live[swap_bit ^ 1] && $urandom_range(0, 3) == 0) rq.req_type = REQ_CONNECT;
    else if (w < 3) rq.req_type = REQ_OPEN;
    else if (w < 10) rq.req_type = REQ_CONNECT;
    else if (w < 52) rq.req_type = REQ_WRITE;
    else if (w < 78) rq.req_type = REQ_READ;
    else if (w < 90) rq.req_type = REQ_STATUS;
    else if (w < 94) rq.req_type = REQ_DISCONNECT;
    else if (w < 97) rq.req_type = REQ_SESSION_END;
    else rq.req_type = REQ_UNUSED;
    if ((rq.req_type == REQ_OPEN || rq.req_type == REQ_CONNECT) && $urandom_range(0, 9) < 7)
      rq.endpoint_id = ID_BITS'($urandom);
    return rq;
  endfunction

  task automatic issue(input req_t rq, input logic typed, input res_t want);
    res_t model;
    while (!no_idle && $urandom_range(0, 99) < 15) begin
      in_tvalid <= 1'b0;
      @(negedge clk);
    end
    in_tvalid <= 1'b1;
    in_tuser  <= rq.req_type;
    in_tdata  <= {1'b0, rq.depth_request, rq.end_kill, rq.packet_length,
                  rq.packet_handle, rq.endpoint_id};
    @(posedge clk);
    while (!in_tready) @(posedge clk);
    model = mailbox_outcome(rq);
    pending_results.insert(pending_results.size(), typed ? want : model);
    @(negedge clk);
  endtask

  task automatic check_field(input string name, input logic [31:0] want, input logic [31:0] got);
    if (want !== got) begin
      $error("%s mismatch: expected 0x%0h, actual 0x%0h", name, want, got);
      mismatches++;
    end
  endtask

  always @(negedge clk) begin
    if (!rst_n) out_tready <= 1'b0;
    else out_tready <= no_idle || ($urandom_range(0, 99) >= 15);
  end

  always @(posedge clk) begin
    res_t want;
    res_t got;
    if (rst_n && out_tvalid && out_tready) begin
      if (pending_results.size() == 0) begin
        $error("result beat 0x%0h arrived with no request outstanding", out_tdata);
        mismatches++;
      end else begin
        want = pending_results.pop_front();
        got.accepted    = out_tdata[0];
        got.read_handle = out_tdata[32:1];
        got.read_length = out_tdata[48:33];
        got.link_status = out_tdata[50:49];
        got.own_fill    = out_tdata[55:51];
        got.peer_fill   = out_tdata[60:56];
        got.tube_gone   = out_tdata[61];
        got.drop_flag   = out_tdata[62];
        got.drop_handle = out_tdata[94:63];
        check_field("accepted", 32'(want.accepted), 32'(got.accepted));
        check_field("read_handle", 32'(want.read_handle), 32'(got.read_handle));
        check_field("read_length", 32'(want.read_length), 32'(got.read_length));
        check_field("link_status", 32'(want.link_status), 32'(got.link_status));
        check_field("own_fill", 32'(want.own_fill), 32'(got.own_fill));
        check_field("peer_fill", 32'(want.peer_fill), 32'(got.peer_fill));
        check_field("tube_gone", 32'(want.tube_gone), 32'(got.tube_gone));
        check_field("drop_flag", 32'(want.drop_flag), 32'(got.drop_flag));
        check_field("drop_handle", 32'(want.drop_handle), 32'(got.drop_handle));
        check_field("pad", 32'b0, 32'(out_tdata[95]));
      end
    end
  end

  always @(posedge clk) begin
    if ((in_tvalid && in_tready) || (out_tvalid && out_tready)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= STALL_LIMIT) begin
      $display("DONE: errors detected");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  initial begin
    rst_n        = 1'b0;
    in_tvalid    = 1'b0;
    in_tdata     = '0;
    in_tuser     = '0;
    out_tready   = 1'b0;
    mismatches   = 0;
    quiet_cycles = 0;
    no_idle      = 1'b0;
    shut_tube();

    add_row(row(REQ_STATUS, 16'h1234, '0, '0, 1'b0, '0, 1'b1, 1'b0, LINK_NONE));
    add_row(row(REQ_WRITE, 16'h1234, '1, '1, 1'b1, '1, 1'b1, 1'b0, LINK_NONE));
    add_row(row(REQ_CONNECT, 16'h1234, '0, '0, 1'b1, 14'd4, 1'b1, 1'b0, LINK_NONE));
    add_row(row(REQ_SESSION_END, 16'h0000, '0, '0, 1'b0, '0, 1'b1, 1'b0,
                LINK_NONE));
    add_row(row(REQ_UNUSED, '1, '1, '1, 1'b1, '1, 1'b1, 1'b0, LINK_NONE));
    add_row(row(REQ_OPEN, 16'h1234, '0, '0, 1'b1, 14'd0, 1'b1, 1'b0, LINK_NONE));
    add_row(row(REQ_WRITE, 16'h1234, '1, '1, 1'b0, '0, 1'b1, 1'b1, LINK_NONE));
    add_row(row(REQ_WRITE, 16'h1234, '0, '0, 1'b0, '0, 1'b1, 1'b1, LINK_NONE));
    add_row(row(REQ_STATUS, 16'h1234, '0, '0, 1'b0, '0, 1'b1, 1'b0,
                LINK_UNCONNECTED));
    add_row(row(REQ_CONNECT, 16'h1234, '0, '0, 1'b1, '1, 1'b1, 1'b0, LINK_NONE));
    add_row(row(REQ_STATUS, 16'h1234, '0, '0, 1'b0, '0, 1'b0, 1'b0, LINK_NONE));
    add_row(row(REQ_READ, 16'h1234, '0, '0, 1'b0, '0, 1'b0, 1'b0, LINK_NONE));
    add_row(row(REQ_DISCONNECT, 16'h1234, '0, '0, 1'b0, '0, 1'b0, 1'b0,
                LINK_NONE));
    add_row(row(REQ_OPEN, 16'hFFFF, '0, '0, 1'b0, 14'd1, 1'b1, 1'b0, LINK_NONE));
    add_row(row(REQ_CONNECT, 16'h0000, '0, '0, 1'b1, 14'd2, 1'b1, 1'b0,
                LINK_NONE));
    add_row(row(REQ_WRITE, 16'h0000, 32'h1111_1111, 16'h0011, 1'b0, '0, 1'b0,
                1'b0, LINK_NONE));
    add_row(row(REQ_WRITE, 16'h0000, 32'h2222_2222, 16'h0022, 1'b0, '0, 1'b0,
                1'b0, LINK_NONE));
    add_row(row(REQ_WRITE, 16'hFFFF, 32'hAAAA_AAAA, 16'h00AA, 1'b0, '0, 1'b0,
                1'b0, LINK_NONE));
    add_row(row(REQ_WRITE, 16'hFFFF, 32'hBBBB_BBBB, 16'h00BB, 1'b0, '0, 1'b0,
                1'b0, LINK_NONE));
    add_row(row(REQ_WRITE, 16'hFFFF, 32'hCCCC_CCCC, 16'h00CC, 1'b0, '0, 1'b0,
                1'b0, LINK_NONE));
    add_row(row(REQ_CONNECT, 16'h0000, '0, '0, 1'b1, 14'd1, 1'b1, 1'b0,
                LINK_NONE));
    add_row(row(REQ_WRITE, 16'hFFFF, 32'hDDDD_DDDD, 16'h00DD, 1'b0, '0, 1'b0,
                1'b0, LINK_NONE));
    add_row(row(REQ_READ, 16'hFFFF, '0, '0, 1'b0, '0, 1'b0, 1'b0, LINK_NONE));
    add_row(row(REQ_READ, 16'h0000, '0, '0, 1'b0, '0, 1'b0, 1'b0, LINK_NONE));
    add_row(row(REQ_DISCONNECT, 16'hFFFF, '0, '0, 1'b0, '0, 1'b0, 1'b0,
                LINK_NONE));
    add_row(row(REQ_STATUS, 16'h0000, '0, '0, 1'b0, '0, 1'b0, 1'b0, LINK_NONE));
    add_row(row(REQ_SESSION_END, 16'h0000, '0, '0, 1'b0, '0, 1'b0, 1'b0,
                LINK_NONE));

    repeat (7) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    foreach (dir_rows[k]) issue(dir_rows[k].rq, dir_rows[k].typed, dir_rows[k].want);

    for (int k = 0; k < RANDOM_REQUESTS; k++) begin
      no_idle = (k >= 700 && k < 1000);
      issue(random_request(), 1'b0, '0);
    end
    no_idle = 1'b0;
    in_tvalid <= 1'b0;

    while (pending_results.size() != 0) @(posedge clk);
    repeat (20) @(posedge clk);
    if (mismatches == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end

endmodule
